// ===== rtl/calendar_alarm_table_match_defines.svh =====
// ----------------------------------------------------------------------------
// calendar alarm table match: assertion macros
// shared assertion forms for the checker of the alarm table block
// ----------------------------------------------------------------------------
`ifndef CALENDAR_ALARM_TABLE_MATCH_DEFINES_SVH
`define CALENDAR_ALARM_TABLE_MATCH_DEFINES_SVH

// checked only out of reset
`define CATM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("catm assertion failed");

// checked at every edge, reset included
`define CATM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("catm assertion failed");

`endif

// ===== rtl/catm_pkg.sv =====
// ----------------------------------------------------------------------------
// catm_pkg
// types, constants and control structs of the calendar alarm table block
// ----------------------------------------------------------------------------
package catm_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int RES_W           = $clog2(MAX_RESULTS);
    localparam int SLOT_W          = 4;
    localparam int KIND_W          = 8;
    localparam int CFG_ADDR_W      = 3;
    localparam int ENTRIES_W       = 5;

    // request opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_ENABLE  = 1'b0;
    localparam logic REG_ENTRIES = 1'b1;

    // calendar limits
    localparam int WILDCARD    = -1;
    localparam int MONTH_MIN   = 1;
    localparam int MONTH_MAX   = 12;
    localparam int DAY_MIN     = 1;
    localparam int DAY_MAX     = 31;
    localparam int FEBRUARY    = 2;
    localparam int FEB_DAY_MAX = 28;
    localparam int WDAY_MAX    = 6;
    localparam int HOUR_MAX    = 23;
    localparam int HOUR_WRAP   = 24;
    localparam int MINUTE_MAX  = 59;
    localparam int MINUTE_WRAP = 60;

    typedef struct packed {
        logic signed [6:0] minute;
        logic signed [5:0] hour;
        logic signed [3:0] weekday;
        logic signed [5:0] day;
        logic signed [4:0] month;
    } t_time;

    typedef struct packed {
        t_time              when;
        logic [KIND_W-1:0]  kind;
    } t_entry;

    // request payload, slot in the lowest bits
    typedef struct packed {
        t_time              when;
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
    } t_s_data;

    typedef struct packed {
        logic write;
        logic start;
        logic advance;
        logic load;
        logic push;
        logic push_last;
    } t_dp_cmd;

    typedef struct packed {
        logic match;
        logic scan_last;
        logic res_last;
        logic out_free;
        logic scan_empty;
    } t_dp_stat;

endpackage

// ===== rtl/catm_ram.sv =====
// ----------------------------------------------------------------------------
// catm_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module catm_ram #(
    parameter int WIDTH  = 36,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/catm_regs.sv =====
// ----------------------------------------------------------------------------
// catm_regs
// configuration registers behind the apb port
// ----------------------------------------------------------------------------
module catm_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_psel,
    input  logic                                 i_penable,
    input  logic                                 i_pwrite,
    input  logic [catm_pkg::CFG_ADDR_W-1:0]      i_paddr,
    input  logic [31:0]                          i_pwdata,
    output logic [31:0]                          o_prdata,
    output logic                                 o_pready,
    output logic                                 o_enable,
    output logic [catm_pkg::ENTRIES_W-1:0]       o_entries
);

    import catm_pkg::*;

    logic                 r_enable;
    logic [ENTRIES_W-1:0] r_entries;
    logic                 wr;

    assign wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_entries <= '0;
        end else if (wr) begin
            case (i_paddr[2])
                REG_ENABLE:  r_enable  <= i_pwdata[0];
                REG_ENTRIES: r_entries <= i_pwdata[ENTRIES_W-1:0];
                default:     r_enable  <= r_enable;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            REG_ENABLE:  o_prdata = {31'b0, r_enable};
            REG_ENTRIES: o_prdata = {{(32-ENTRIES_W){1'b0}}, r_entries};
            default:     o_prdata = '0;
        endcase
    end

    assign o_pready  = 1'b1;
    assign o_enable  = r_enable;
    assign o_entries = r_entries;

endmodule

// ===== rtl/catm_ctrl.sv =====
// ----------------------------------------------------------------------------
// catm_ctrl
// sequencer for table writes, scans and result hand-off
// ----------------------------------------------------------------------------
module catm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tuser,
    output logic                o_s_tready,
    input  catm_pkg::t_dp_stat  i_stat,
    output catm_pkg::t_dp_cmd   o_cmd
);

    import catm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_H,
        S_FLUSH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;
    logic    accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_tuser == OP_WRITE) begin
                        cmd.write = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                        if (!i_stat.scan_empty) begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    cmd.load = 1'b1;
                    if (i_stat.res_last || i_stat.scan_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        cmd.advance = 1'b1;
                        n_state     = S_SCAN_H;
                    end
                end else if (i_stat.scan_last) begin
                    n_state = S_IDLE;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            S_SCAN_H: begin
                if (i_stat.match) begin
                    // held result leaves before the new one takes its place
                    if (i_stat.out_free) begin
                        cmd.push = 1'b1;
                        cmd.load = 1'b1;
                        if (i_stat.res_last || i_stat.scan_last) begin
                            n_state = S_FLUSH;
                        end else begin
                            cmd.advance = 1'b1;
                        end
                    end
                end else if (i_stat.scan_last) begin
                    n_state = S_FLUSH;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

endmodule

// ===== rtl/catm_dp.sv =====
// ----------------------------------------------------------------------------
// catm_dp
// alarm table, entry matcher, held result and output register
// ----------------------------------------------------------------------------
module catm_dp #(
    parameter int TABLE_DEPTH = catm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  catm_pkg::t_dp_cmd                i_cmd,
    output catm_pkg::t_dp_stat               o_stat,
    input  logic [39:0]                      i_s_tdata,
    input  logic                             i_enable,
    input  logic [catm_pkg::ENTRIES_W-1:0]   i_entries,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [15:0]                      o_m_tdata,
    output logic                             o_m_tlast
);

    import catm_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    function automatic logic entry_match(t_entry e, t_time t);
        logic              ok;
        logic signed [5:0] h;
        logic signed [6:0] n;
        ok = 1'b1;
        if (e.when.month != WILDCARD) begin
            if (e.when.month < MONTH_MIN || e.when.month > MONTH_MAX
                || e.when.month != t.month) begin
                ok = 1'b0;
            end
        end
        if (e.when.day != WILDCARD) begin
            if (e.when.day < DAY_MIN || e.when.day > DAY_MAX
                || (t.month == FEBRUARY && e.when.day > FEB_DAY_MAX)
                || e.when.day != t.day) begin
                ok = 1'b0;
            end
        end
        if (e.when.weekday != WILDCARD) begin
            if (e.when.weekday < 0 || e.when.weekday > WDAY_MAX
                || e.when.weekday != t.weekday) begin
                ok = 1'b0;
            end
        end
        h = (e.when.hour == HOUR_WRAP) ? '0 : e.when.hour;
        if (h < 0 || h > HOUR_MAX || h != t.hour) begin
            ok = 1'b0;
        end
        n = (e.when.minute == MINUTE_WRAP) ? '0 : e.when.minute;
        if (n < 0 || n > MINUTE_MAX || n != t.minute) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    t_s_data            req;
    t_entry             wr_entry;
    t_entry             rd_entry;
    logic               slot_ok;
    logic [AW-1:0]      n_idx;
    logic [CW-1:0]      sat_count;

    t_time              r_time;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic [RES_W-1:0]   r_nres;
    logic [KIND_W-1:0]  r_held_kind;
    logic [SLOT_W-1:0]  r_held_slot;
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic [SLOT_W-1:0]  r_out_slot;
    logic               r_out_last;

    assign req      = t_s_data'(i_s_tdata);
    assign wr_entry = '{when: req.when, kind: req.kind};
    assign slot_ok  = int'(req.slot) < TABLE_DEPTH;

    assign sat_count = (int'(i_entries) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                        : CW'(i_entries);

    always_comb begin
        if (i_cmd.start) begin
            n_idx = '0;
        end else if (i_cmd.advance) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    catm_ram #(
        .WIDTH  ($bits(t_entry)),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write && slot_ok),
        .i_waddr (AW'(req.slot)),
        .i_wdata (wr_entry),
        .i_raddr (n_idx),
        .o_rdata (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.start) begin
            r_time  <= req.when;
            r_count <= sat_count;
            r_nres  <= '0;
        end
        if (i_cmd.load) begin
            r_held_kind <= rd_entry.kind;
            r_held_slot <= SLOT_W'(r_idx);
            r_nres      <= r_nres + 1'b1;
        end
        if (i_cmd.push) begin
            r_out_kind <= r_held_kind;
            r_out_slot <= r_held_slot;
            r_out_last <= i_cmd.push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.match      = entry_match(rd_entry, r_time);
    assign o_stat.scan_last  = (CW'(r_idx) == r_count - 1'b1);
    assign o_stat.res_last   = (r_nres == RES_W'(MAX_RESULTS - 1));
    assign o_stat.out_free   = !r_out_valid || i_m_tready;
    assign o_stat.scan_empty = !i_enable || (i_entries == '0);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(16 - SLOT_W - KIND_W){1'b0}}, r_out_slot, r_out_kind};
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/calendar_alarm_table_match.sv =====
// ----------------------------------------------------------------------------
// calendar_alarm_table_match
// Alarm table with calendar time match. A write request (tuser 0) stores one
// entry in a slot. A check request (tuser 1) scans slots 0 to
// entries_in_use-1, capped at the table depth, one entry per cycle unless the
// result side stalls, through the single read port of the table, and returns
// kind and slot of each matching entry, tlast on the final one, at most
// sixteen per check. A check holds the request side through its scan, and
// longer while the result side stalls; with enable clear or entries_in_use
// zero it ends without a scan. No new request is taken until the final
// result of a check sits in the output register.
// ----------------------------------------------------------------------------
module calendar_alarm_table_match #(
    parameter int TABLE_DEPTH = catm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // slot[3:0] kind[11:4] month[16:12] day[22:17] weekday[26:23]
    // hour[32:27] minute[39:33]
    input  logic [39:0]                      i_s_tdata,
    // opcode[0]
    input  logic                             i_s_tuser,
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // event_kind[7:0] match_slot[11:8] zero[15:12]
    output logic [15:0]                      o_m_tdata,
    output logic                             o_m_tlast,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [catm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import catm_pkg::*;

    t_dp_cmd              cmd;
    t_dp_stat             stat;
    logic                 enable;
    logic [ENTRIES_W-1:0] entries;

    catm_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_enable  (enable),
        .o_entries (entries)
    );

    catm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    catm_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .i_enable   (enable),
        .i_entries  (entries),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== rtl/catm_checker.sv =====
// ----------------------------------------------------------------------------
// catm_checker
// port-level assertions for the alarm table block, bound to the top level
// ----------------------------------------------------------------------------
`include "calendar_alarm_table_match_defines.svh"

module catm_checker #(
    parameter int TABLE_DEPTH = catm_pkg::TABLE_DEPTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic        i_m_tlast
);

    // stalled result holds
    `CATM_ASSERT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))

    // no new request while a check still has results to give
    `CATM_ASSERT(a_busy_mid_check, i_clk, i_rst_n, i_m_tvalid && !i_m_tlast |-> !i_s_tready)

    // results of one check come in rising slot order
    `CATM_ASSERT(a_slot_order, i_clk, i_rst_n, i_m_tvalid && i_m_tready && !i_m_tlast |=> !i_m_tvalid || (TABLE_DEPTH > 16) || (i_m_tdata[11:8] > $past(i_m_tdata[11:8])))

    // reset leaves the block empty and ready
    `CATM_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> !i_m_tvalid && i_s_tready)

endmodule

bind calendar_alarm_table_match catm_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_catm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for calendar_alarm_table_match
// Writes alarm entries over the request stream and programs the scan registers
// over the configuration port, then issues time checks. A shadow alarm table
// in the bench predicts every matching entry of a check, in slot order with
// tlast on the final one, and each result taken from the block is compared
// with the oldest predicted match. Directed tests cover the field extremes,
// the wildcard and wrap rules, the february rule, out-of-range check times,
// scan length saturation and the enable bit. Random traffic follows, built
// mostly from entries aimed at a small set of calendar times, with
// back-pressure and request gaps varied between phases.
// ----------------------------------------------------------------------------
module testbench;
    import catm_pkg::*;

    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH_DEF;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_alarm_hit;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // slot[3:0] kind[11:4] month[16:12] day[22:17] weekday[26:23]
    // hour[32:27] minute[39:33]
    logic [39:0]           i_s_tdata  = '0;
    // opcode[0]
    logic                  i_s_tuser  = OP_WRITE;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // event_kind[7:0] match_slot[11:8] zero[15:12]
    logic [15:0]           o_m_tdata;
    logic                  o_m_tlast;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr      = '0;
    logic [31:0]           pwdata     = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // shadow of the block state
    t_entry                alarm_shadow [TABLE_DEPTH_DEF];
    logic                  alarm_on = 1'b0;
    logic [ENTRIES_W-1:0]  scan_len = '0;

    t_alarm_hit            due_alarms [$];
    int unsigned           mismatch_count     = 0;
    int unsigned           sender_gap_pct     = 0;
    int unsigned           receiver_stall_pct = 0;

    calendar_alarm_table_match dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic t_time alarm_time(input int m, input int d, input int w,
                                         input int h, input int n);
        t_time t;
        t.month   = 5'(m);
        t.day     = 6'(d);
        t.weekday = 4'(w);
        t.hour    = 6'(h);
        t.minute  = 7'(n);
        return t;
    endfunction

    function automatic bit alarm_hits(input t_entry e, input t_time now);
        int m, d, w, h, n;
        int cm, cd, cw, ch, cn;
        m  = int'(e.when.month);
        d  = int'(e.when.day);
        w  = int'(e.when.weekday);
        h  = int'(e.when.hour);
        n  = int'(e.when.minute);
        cm = int'(now.month);
        cd = int'(now.day);
        cw = int'(now.weekday);
        ch = int'(now.hour);
        cn = int'(now.minute);
        if (h == HOUR_WRAP) h = 0;
        if (n == MINUTE_WRAP) n = 0;
        if (m != WILDCARD && (m < MONTH_MIN || m > MONTH_MAX || m != cm)) return 1'b0;
        if (d != WILDCARD && (d < DAY_MIN || d > DAY_MAX ||
                              (cm == FEBRUARY && d > FEB_DAY_MAX) || d != cd)) return 1'b0;
        if (w != WILDCARD && (w < 0 || w > WDAY_MAX || w != cw)) return 1'b0;
        if (h < 0 || h > HOUR_MAX || h != ch) return 1'b0;
        if (n < 0 || n > MINUTE_MAX || n != cn) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_due_alarms(input t_time now);
        int         scan;
        int         found;
        t_alarm_hit hit;
        if (!alarm_on) return;
        scan  = (scan_len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(scan_len);
        found = 0;
        for (int i = 0; i < scan; i++) begin
            if (found < MAX_RESULTS && alarm_hits(alarm_shadow[i], now)) begin
                hit.kind = alarm_shadow[i].kind;
                hit.slot = SLOT_W'(i);
                hit.last = 1'b0;
                due_alarms.push_back(hit);
                found++;
            end
        end
        if (found > 0) due_alarms[due_alarms.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", what);
    endfunction

    always @(posedge i_clk) begin : result_check
        t_alarm_hit want;
        t_alarm_hit seen;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.kind = o_m_tdata[KIND_W-1:0];
            seen.slot = o_m_tdata[KIND_W+SLOT_W-1:KIND_W];
            seen.last = o_m_tlast;
            if (due_alarms.size() == 0) begin
                note_mismatch($sformatf("unexpected result kind %02h slot %0d last %0b",
                                        seen.kind, seen.slot, seen.last));
            end else begin
                want = due_alarms.pop_front();
                if (seen.kind !== want.kind || seen.slot !== want.slot ||
                    seen.last !== want.last) begin
                    note_mismatch($sformatf(
                        "expected kind %02h slot %0d last %0b, got kind %02h slot %0d last %0b",
                        want.kind, want.slot, want.last, seen.kind, seen.slot, seen.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot,
                                input logic [KIND_W-1:0] kind, input t_time when);
        t_s_data payload;
        payload = '{when: when, kind: kind, slot: slot};
        if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= payload;
        do @(posedge i_clk); while (!o_s_tready);
        if (op == OP_WRITE) alarm_shadow[slot] = '{when: when, kind: kind};
        else predict_due_alarms(when);
    endtask

    // hold off requests until every predicted match has been taken
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (due_alarms.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ENABLE) alarm_on = value[0];
        else scan_len = value[ENTRIES_W-1:0];
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_time random_calendar();
        return alarm_time($urandom_range(MONTH_MAX, MONTH_MIN), $urandom_range(DAY_MAX, DAY_MIN),
                          $urandom_range(WDAY_MAX), $urandom_range(HOUR_MAX),
                          $urandom_range(MINUTE_MAX));
    endfunction

    function automatic t_time raw_time();
        logic [31:0] raw;
        raw = $urandom;
        return raw[$bits(t_time)-1:0];
    endfunction

    // entry aimed at a given time, with wildcards and wrap aliases mixed in
    function automatic t_time alarm_for(input t_time now);
        t_time t;
        t = now;
        if ($urandom_range(2) == 0) t.month = 5'(WILDCARD);
        if ($urandom_range(2) == 0) t.day = 6'(WILDCARD);
        if ($urandom_range(1) == 0) t.weekday = 4'(WILDCARD);
        if (now.hour == 0 && $urandom_range(1) == 0) t.hour = 6'(HOUR_WRAP);
        if (now.minute == 0 && $urandom_range(1) == 0) t.minute = 7'(MINUTE_WRAP);
        if ($urandom_range(9) == 0) t.day = 6'($urandom_range(DAY_MAX, FEB_DAY_MAX + 1));
        return t;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_check_after_reset();
        send_request(OP_CHECK, 4'h0, 8'h00, alarm_time(1, 1, 0, 0, 0));
        drain_results();
    endtask

    // table filled while disabled, every slot written once
    task automatic test_table_fill();
        send_request(OP_WRITE, 0,  8'h00, alarm_time(-1, -1, -1, 24, 60));
        send_request(OP_WRITE, 1,  8'hFF, alarm_time(2, 29, -1, 0, 0));
        send_request(OP_WRITE, 2,  8'h12, alarm_time(13, 1, 1, 0, 0));
        send_request(OP_WRITE, 3,  8'h34, alarm_time(12, 31, 6, 23, 59));
        send_request(OP_WRITE, 4,  8'h56, alarm_time(1, 0, 0, 0, 0));
        send_request(OP_WRITE, 5,  8'h78, alarm_time(1, 1, 7, 0, 0));
        send_request(OP_WRITE, 6,  8'h9A, alarm_time(-1, -1, -1, -1, 0));
        send_request(OP_WRITE, 7,  8'hBC, alarm_time(-1, -1, -1, 0, -1));
        send_request(OP_WRITE, 8,  8'hDE, alarm_time(-1, -1, -1, 31, 0));
        send_request(OP_WRITE, 9,  8'hF0, alarm_time(-1, -1, -1, 0, 63));
        send_request(OP_WRITE, 10, 8'h0F, alarm_time(-1, -1, -1, 23, 59));
        send_request(OP_WRITE, 11, 8'h81, alarm_time(1, 1, 0, 0, 0));
        send_request(OP_WRITE, 12, 8'h42, alarm_time(-16, -32, -8, 0, 0));
        send_request(OP_WRITE, 13, 8'h24, alarm_time(-1, 31, -1, 23, 59));
        send_request(OP_WRITE, 14, 8'hC3, alarm_time(2, 28, -1, 0, 0));
        send_request(OP_WRITE, 15, 8'hA5, alarm_time(-1, -1, -1, 0, 0));
        drain_results();
    endtask

    task automatic test_directed_matches();
        write_register(REG_ENABLE, 32'd1);
        write_register(REG_ENTRIES, TABLE_DEPTH_DEF);
        // late day in february
        send_request(OP_CHECK, 4'hF, 8'hFF, alarm_time(2, 29, 3, 0, 0));
        send_request(OP_CHECK, 4'h0, 8'h00, alarm_time(2, 28, 3, 0, 0));
        send_request(OP_CHECK, 4'h5, 8'h5A, alarm_time(12, 31, 6, 23, 59));
        send_request(OP_CHECK, 4'hA, 8'hA5, alarm_time(1, 1, 0, 0, 0));
        // check time out of range is compared as given
        send_request(OP_CHECK, 4'h3, 8'h3C, alarm_time(13, -1, 7, 0, 0));
        send_request(OP_CHECK, 4'hC, 8'hC3, alarm_time(-1, -1, -1, -1, -1));
        drain_results();
    endtask

    task automatic test_scan_limits();
        // scan length above the table depth saturates
        write_register(REG_ENTRIES, 32'd31);
        send_request(OP_CHECK, 4'h0, 8'h00, alarm_time(2, 28, 3, 0, 0));
        drain_results();
        write_register(REG_ENTRIES, 32'd1);
        send_request(OP_CHECK, 4'h0, 8'h00, alarm_time(1, 1, 0, 0, 0));
        drain_results();
        write_register(REG_ENTRIES, 32'd0);
        send_request(OP_CHECK, 4'h0, 8'h00, alarm_time(1, 1, 0, 0, 0));
        drain_results();
        write_register(REG_ENTRIES, TABLE_DEPTH_DEF);
        write_register(REG_ENABLE, 32'd0);
        send_request(OP_CHECK, 4'h0, 8'h00, alarm_time(1, 1, 0, 0, 0));
        drain_results();
    endtask

    task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                       input int count, input int scan);
        t_time             pool [3];
        t_time             when;
        logic [SLOT_W-1:0] slot;
        logic [KIND_W-1:0] kind;
        int                roll;
        int                k;
        drain_results();
        write_register(REG_ENABLE, 32'd1);
        write_register(REG_ENTRIES, scan);
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        pool[0]            = random_calendar();
        pool[0].month      = 5'(FEBRUARY);
        pool[1]            = random_calendar();
        pool[2]            = random_calendar();
        pool[2].hour       = '0;
        pool[2].minute     = '0;
        for (k = 0; k < count; k++) begin
            if (k == count / 2) begin
                drain_results();
                write_register(REG_ENTRIES, $urandom_range(TABLE_DEPTH_DEF, 1));
            end
            roll = $urandom_range(99);
            slot = SLOT_W'($urandom_range(TABLE_DEPTH_DEF - 1));
            kind = KIND_W'($urandom_range(255));
            if (roll < 40) begin
                if ($urandom_range(4) == 0) when = raw_time();
                else when = alarm_for(pool[$urandom_range(2)]);
                send_request(OP_WRITE, slot, kind, when);
            end else begin
                roll = $urandom_range(19);
                if (roll == 0) when = raw_time();
                else if (roll < 4) when = random_calendar();
                else when = pool[$urandom_range(2)];
                send_request(OP_CHECK, slot, kind, when);
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n            <= 1'b1;
        sender_gap_pct     = 11;
        receiver_stall_pct = 54;
        test_check_after_reset();
        test_table_fill();
        test_directed_matches();
        test_scan_limits();
        test_random_traffic(11, 54, 32, TABLE_DEPTH_DEF);
        test_random_traffic(54, 11, 32, 31);
        test_random_traffic(0, 0, 32, 12);
        drain_results();
        if (mismatch_count == 0 && due_alarms.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
